@@ hw/rtl/flfh_pkg.sv @@
// ----------------------------------------------------------------------------
// flfh_pkg: shared types and constants
// Payload structs, register indexes and filter and hold constants.
// ----------------------------------------------------------------------------
package flfh_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 12;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROUNDS  = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD    = 8'd3;

    // filter and hold constants
    localparam int MIN_SURVIVORS = 10;
    localparam logic [SAMPLE_BITS-1:0] TH_ON      = 12'd500;
    localparam logic [SAMPLE_BITS-1:0] TH_KEEP    = 12'd450;
    localparam logic [SAMPLE_BITS:0]   STEP_LIMIT = 13'd500;
    localparam logic [3:0] INVALID_LIMIT = 4'd10;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic                   signal_present;
        logic                   too_few;
    } out_item_t;

endpackage

@@ hw/rtl/frame_level_filter_with_hold.sv @@
// ----------------------------------------------------------------------------
// frame_level_filter_with_hold: frame filter with anti-flicker hold
// Buffers a frame, runs mean-raising selection rounds and a trimmed mean
// over it with one shared serial divider, then applies the hold stage.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_ready, in_data    | sink
//  out     | out_valid, out_ready, out_data | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// On last the block runs up to rounds+1 passes over the n buffered samples
// (memory read, then use for each sample) with one serial division after
// each pass; too few survivors or an empty frame skip it and go straight
// to the hold step. in_ready is low during that work. The result sits
// in an output register; a new frame can be collected while it waits. Reset
// clears all control and hold state; the buffer needs no clearing.
module frame_level_filter_with_hold
    import flfh_pkg::*;
#(
    parameter int MAX_SAMPLES = 512
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = CNT_W + SAMPLE_BITS;
    localparam int DIT_W  = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_USE   = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_HOLD  = 3'd6;

    // configuration
    logic [SAMPLE_BITS-1:0] noise_reg;
    logic [SAMPLE_BITS-1:0] trigger_reg;
    logic [3:0]             rounds_reg;
    logic                   hold_en_reg;

    // frame buffer
    logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    // sequencer state
    logic [2:0]             state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       i_reg;
    logic [CNT_W-1:0]       m_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [3:0]             round_reg;
    logic                   final_reg;
    logic                   few_reg;
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [SAMPLE_BITS-1:0] max1_reg, max2_reg, min1_reg, min2_reg;

    // divider
    logic [SUM_W-1:0]       num_reg;
    logic [CNT_W-1:0]       den_reg;
    logic [CNT_W:0]         rem_reg;
    logic [SUM_W-1:0]       quo_reg;
    logic [DIT_W-1:0]       dit_reg;

    // hold state
    logic                   hold_reg;
    logic [SAMPLE_BITS-1:0] held_reg;
    logic [SAMPLE_BITS-1:0] cand_reg;
    logic [1:0]             cc_reg;
    logic [3:0]             inv_reg;

    // output register
    logic                   out_valid_reg;
    out_item_t              out_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sample after noise gate
    logic [SAMPLE_BITS-1:0] v;
    assign v = (rdata_reg < noise_reg) ? '0 : rdata_reg;

    // frame length including the last transfer
    logic [CNT_W-1:0] len;
    assign len = (cnt_reg < MAX_CNT) ? cnt_reg + CNT_W'(1) : cnt_reg;

    // divider step
    logic [CNT_W:0] rem_sh;
    logic           rem_ge;
    assign rem_sh = {rem_reg[CNT_W-1:0], num_reg[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    // trimmed sum for the final pass
    logic [SUM_W-1:0] trim_sum;
    assign trim_sum = sum_reg - SUM_W'(max1_reg) - SUM_W'(max2_reg)
                              - SUM_W'(min1_reg) - SUM_W'(min2_reg);

    // hold stage
    logic [SAMPLE_BITS-1:0] th;
    logic [SAMPLE_BITS:0]   d_held, d_cand;
    logic [3:0]             inv_inc;
    logic                   h_hold;
    logic [SAMPLE_BITS-1:0] h_held, h_cand, h_level;
    logic [1:0]             h_cc;
    logic [3:0]             h_inv;

    always_comb
    begin
        th      = hold_reg ? TH_KEEP : TH_ON;
        d_held  = (raw_reg > held_reg) ? {1'b0, raw_reg} - {1'b0, held_reg}
                                       : {1'b0, held_reg} - {1'b0, raw_reg};
        d_cand  = (raw_reg > cand_reg) ? {1'b0, raw_reg} - {1'b0, cand_reg}
                                       : {1'b0, cand_reg} - {1'b0, raw_reg};
        inv_inc = (inv_reg < INVALID_LIMIT) ? inv_reg + 4'd1 : inv_reg;
        h_hold  = hold_reg;
        h_held  = held_reg;
        h_cand  = cand_reg;
        h_cc    = cc_reg;
        h_inv   = inv_reg;
        h_level = '0;
        if (raw_reg >= th)
        begin
            h_inv = '0;
            if (hold_reg && held_reg != '0 && d_held > STEP_LIMIT
                && (cc_reg == 2'd0 || d_cand > STEP_LIMIT))
            begin
                // first sighting of a large jump: remember it, keep old level
                h_cand  = raw_reg;
                h_cc    = 2'd1;
                h_level = held_reg;
            end
            else
            begin
                h_hold  = 1'b1;
                h_held  = raw_reg;
                h_cc    = 2'd0;
                h_cand  = '0;
                h_level = raw_reg;
            end
        end
        else
        begin
            h_cc   = 2'd0;
            h_cand = '0;
            h_inv  = inv_inc;
            if (inv_inc >= INVALID_LIMIT)
            begin
                h_hold  = 1'b0;
                h_held  = '0;
                h_level = '0;
            end
            else
            begin
                h_level = hold_reg ? held_reg : '0;
            end
        end
    end

    // frame buffer: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && cnt_reg < MAX_CNT)
            mem[cnt_reg[ADDR_W-1:0]] <= in_data.sample;
        else if (state_reg == ST_USE && !final_reg && v >= avg_reg)
            mem[m_reg[ADDR_W-1:0]] <= v;
        rdata_reg <= mem[i_reg[ADDR_W-1:0]];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg   <= 12'd300;
            trigger_reg <= 12'd100;
            rounds_reg  <= 4'd4;
            hold_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NOISE:   noise_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_TRIGGER: trigger_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_ROUNDS:  rounds_reg  <= cfg_data[3:0];
                REG_HOLD:    hold_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath and hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            held_reg      <= '0;
            cand_reg      <= '0;
            cc_reg        <= '0;
            inv_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.last)
                        begin
                            n_reg     <= len;
                            cnt_reg   <= '0;
                            avg_reg   <= trigger_reg;
                            round_reg <= '0;
                            few_reg   <= 1'b0;
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            cnt_reg <= len;
                        end
                    end
                end
                ST_START:
                begin
                    i_reg     <= '0;
                    m_reg     <= '0;
                    sum_reg   <= '0;
                    max1_reg  <= '0;
                    max2_reg  <= '0;
                    min1_reg  <= '1;
                    min2_reg  <= '1;
                    final_reg <= (round_reg == rounds_reg);
                    state_reg <= (n_reg == '0) ? ST_END : ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_USE;
                end
                ST_USE:
                begin
                    if (!final_reg)
                    begin
                        if (v >= avg_reg)
                        begin
                            m_reg   <= m_reg + CNT_W'(1);
                            sum_reg <= sum_reg + SUM_W'(v);
                        end
                    end
                    else
                    begin
                        sum_reg <= sum_reg + SUM_W'(v);
                        if (v > max1_reg)
                        begin
                            max1_reg <= v;
                            max2_reg <= max1_reg;
                        end
                        else if (v > max2_reg)
                            max2_reg <= v;
                        if (v < min1_reg)
                        begin
                            min1_reg <= v;
                            min2_reg <= min1_reg;
                        end
                        else if (v < min2_reg)
                            min2_reg <= v;
                    end
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= (i_reg + CNT_W'(1) == n_reg) ? ST_END : ST_RD;
                end
                ST_END:
                begin
                    rem_reg <= '0;
                    dit_reg <= DIT_W'(SUM_W);
                    if (!final_reg)
                    begin
                        n_reg <= m_reg;
                        if (m_reg < CNT_W'(MIN_SURVIVORS))
                        begin
                            few_reg   <= 1'b1;
                            raw_reg   <= '0;
                            state_reg <= ST_HOLD;
                        end
                        else
                        begin
                            num_reg   <= sum_reg;
                            den_reg   <= m_reg;
                            state_reg <= ST_DIV;
                        end
                    end
                    else if (n_reg == '0)
                    begin
                        raw_reg   <= '0;
                        state_reg <= ST_HOLD;
                    end
                    else if (n_reg <= CNT_W'(4))
                    begin
                        num_reg   <= sum_reg;
                        den_reg   <= n_reg;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        num_reg   <= trim_sum;
                        den_reg   <= n_reg - CNT_W'(4);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (dit_reg != '0)
                    begin
                        rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                        quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
                        num_reg <= {num_reg[SUM_W-2:0], 1'b0};
                        dit_reg <= dit_reg - DIT_W'(1);
                    end
                    else if (final_reg)
                    begin
                        raw_reg   <= quo_reg[SAMPLE_BITS-1:0];
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        avg_reg   <= quo_reg[SAMPLE_BITS-1:0];
                        round_reg <= round_reg + 4'd1;
                        state_reg <= ST_START;
                    end
                end
                ST_HOLD:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_reg.too_few <= few_reg;
                        if (hold_en_reg)
                        begin
                            out_reg.level          <= h_level;
                            out_reg.signal_present <= h_hold;
                            hold_reg <= h_hold;
                            held_reg <= h_held;
                            cand_reg <= h_cand;
                            cc_reg   <= h_cc;
                            inv_reg  <= h_inv;
                        end
                        else
                        begin
                            out_reg.level          <= raw_reg;
                            out_reg.signal_present <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // frame counter never exceeds the buffer depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("frame count beyond buffer depth");

    // in-place compaction never overtakes the read pointer
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_USE) |-> (m_reg <= i_reg))
        else $error("compaction write index ahead of read index");

    // invalid counter saturates at its limit
    a_inv_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv_reg <= INVALID_LIMIT)
        else $error("invalid counter past limit");

    // a result is only loaded from the hold step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_HOLD))
        else $error("result raised outside hold step");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame level filter with hold
// Sends frames of ADC samples through the block under several register
// settings, predicts each frame's level, presence and too-few flags and
// compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import flfh_pkg::*;

    // Predicts frame levels and holds the predictions until they are checked
    class level_scoreboard;
        logic [11:0] noise_th = 12'd300;
        logic [11:0] trig_lvl = 12'd100;
        logic [3:0]  n_rounds = 4'd4;
        logic        hold_en = 1'b1;
        int          frame_q[$];
        logic        hold_sig = 1'b0;
        logic [11:0] held_lvl = 12'd0;
        logic [11:0] cand_lvl = 12'd0;
        logic [1:0]  cand_cnt = 2'd0;
        logic [3:0]  invalid_cnt = 4'd0;
        out_item_t   pending_q[$];
        int          errors;
        int          frames;
        int          few_frames;

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] val);
            case (idx)
                REG_NOISE:   noise_th = val;
                REG_TRIGGER: trig_lvl = val;
                REG_ROUNDS:  n_rounds = val[3:0];
                REG_HOLD:    hold_en = val[0];
                default: ;
            endcase
        endfunction

        function int dist_abs(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // raw frame level; few is set when a round leaves under ten samples
        function int frame_level(output logic few);
            int v[$];
            int kept[$];
            int avg;
            int sum;
            few = 1'b0;
            avg = trig_lvl;
            foreach (frame_q[i])
                v.push_back((frame_q[i] < noise_th) ? 0 : frame_q[i]);
            for (int r = 0; r < n_rounds; r++) begin
                kept.delete();
                sum = 0;
                foreach (v[i])
                    if (v[i] >= avg) begin
                        kept.push_back(v[i]);
                        sum += v[i];
                    end
                if (kept.size() < MIN_SURVIVORS) begin
                    few = 1'b1;
                    return 0;
                end
                v = kept;
                avg = sum / v.size();
            end
            if (v.size() == 0)
                return 0;
            v.sort();
            sum = 0;
            if (v.size() <= 4) begin
                foreach (v[i])
                    sum += v[i];
                return sum / v.size();
            end
            for (int i = 2; i < v.size() - 2; i++)
                sum += v[i];
            return sum / (v.size() - 4);
        endfunction

        // anti-flicker stage, updates hold state
        function logic [11:0] hold_level(int raw);
            int th;
            th = hold_sig ? TH_KEEP : TH_ON;
            if (raw >= th) begin
                invalid_cnt = 0;
                if (hold_sig && held_lvl > 0 && dist_abs(raw, held_lvl) > STEP_LIMIT) begin
                    if (cand_cnt == 0 || dist_abs(raw, cand_lvl) > STEP_LIMIT) begin
                        cand_lvl = raw[11:0];
                        cand_cnt = 1;
                        return held_lvl;
                    end
                end
                hold_sig = 1'b1;
                held_lvl = raw[11:0];
                cand_cnt = 0;
                cand_lvl = 0;
                return raw[11:0];
            end
            cand_cnt = 0;
            cand_lvl = 0;
            if (invalid_cnt < INVALID_LIMIT)
                invalid_cnt++;
            if (invalid_cnt >= INVALID_LIMIT) begin
                hold_sig = 1'b0;
                held_lvl = 0;
                return 0;
            end
            return hold_sig ? held_lvl : 12'd0;
        endfunction

        function void note_sample(in_item_t it);
            out_item_t exp_item;
            int raw;
            logic few;
            if (frame_q.size() < 512)
                frame_q.push_back(it.sample);
            if (!it.last)
                return;
            raw = frame_level(few);
            frame_q.delete();
            if (hold_en) begin
                exp_item.level = hold_level(raw);
                exp_item.signal_present = hold_sig;
            end else begin
                exp_item.level = raw[11:0];
                exp_item.signal_present = 1'b0;
            end
            exp_item.too_few = few;
            pending_q.push_back(exp_item);
            frames++;
            if (few)
                few_frames++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (pending_q.size() == 0) begin
                $error("unexpected result level=%0d", got.level);
                errors++;
                return;
            end
            exp_item = pending_q.pop_front();
            if (got.level !== exp_item.level) begin
                $error("level: expected %0d, got %0d", exp_item.level, got.level);
                errors++;
            end
            if (got.signal_present !== exp_item.signal_present) begin
                $error("signal_present: expected %0b, got %0b",
                       exp_item.signal_present, got.signal_present);
                errors++;
            end
            if (got.too_few !== exp_item.too_few) begin
                $error("too_few: expected %0b, got %0b", exp_item.too_few, got.too_few);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    level_scoreboard sb;
    bit quiet;        // no idling on either side
    bit long_stall;   // receiver holds off once for a long stretch
    int n_items;

    frame_level_filter_with_hold DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

    // one sample transfer
    task automatic send_sample(logic [11:0] s, logic l);
        in_item_t it;
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.sample = s;
        it.last = l;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(it);
        n_items++;
    endtask

    // register write transfer
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // wait until all results are in and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_all(int nt, int tl, int rn, int he);
        drain();
        write_reg(REG_NOISE, nt[11:0]);
        write_reg(REG_TRIGGER, tl[11:0]);
        write_reg(REG_ROUNDS, rn[11:0]);
        write_reg(REG_HOLD, he[11:0]);
    endtask

    // random frame around a base level with some spread and low noise
    task automatic send_frame(int len, int base, int spread);
        int s;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                s = $urandom_range(0, 4095);
            else
                s = base + $urandom_range(0, 2 * spread) - spread;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
            send_sample(s[11:0], i == len - 1);
        end
    endtask

    // result side with random stalls
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall)
            begin
                long_stall = 1'b0;
                stall = 1000;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    // stimulus
    initial
    begin
        int bases[4];
        int base;
        int len;
        sb = new();
        bases = '{200, 800, 1700, 3500};
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        long_stall = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: too few survivors at reset settings, extremes
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b1);
        // zero rounds: single-sample frame gives a level
        set_all(0, 0, 0, 1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_sample(12'(1000 + i * 10), i == 5);
        // hold disabled, all rounds, max thresholds
        set_all(4095, 4095, 15, 0);
        for (int i = 0; i < 12; i++)
            send_sample(12'd4095, i == 11);

        // random phases over register settings
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 8)
                0: set_all(300, 100, 4, 1);
                1: set_all(0, 0, 1, 1);
                2: set_all($urandom_range(0, 4095), $urandom_range(0, 1500), 2, 1);
                3: set_all(4095, 4095, 15, 1);
                4: set_all(100, 500, 0, 0);
                5: set_all($urandom_range(0, 600), $urandom_range(0, 4095),
                           $urandom_range(0, 15), $urandom_range(0, 1));
                6: set_all(300, 0, 15, 1);
                default: set_all(200, 300, 3, 0);
            endcase
            quiet = (ph % 5 == 3);
            if (ph == 4)
                long_stall = 1'b1;
            // the long-stall phase sends enough frames to back the block up
            for (int f = 0; f < ((ph == 4) ? 4 : 1); f++)
            begin
                base = bases[$urandom_range(0, 3)];
                if ($urandom_range(0, 3) == 0)
                    base = $urandom_range(0, 4095);
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9)
                                                   : $urandom_range(10, 16);
                send_frame(len, base, $urandom_range(0, 300));
            end
        end

        // frame overflow: samples past capacity are dropped
        set_all(300, 100, 1, 1);
        quiet = 1'b1;
        send_frame(515, 2000, 400);
        quiet = 1'b0;
        drain();

        $display("Covered %0d samples in %0d frames (%0d with too few survivors),",
                 n_items, sb.frames, sb.few_frames);
        $display("across varied thresholds, rounds, hold modes and one overflow frame.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
